### rtl/core/slc_pkg.sv
package slc_pkg;

    localparam logic [2:0] KIND_INVALID = 3'd0;
    localparam logic [2:0] KIND_SPECIAL = 3'd1;
    localparam logic [2:0] KIND_CHAR    = 3'd2;
    localparam logic [2:0] KIND_INT     = 3'd3;
    localparam logic [2:0] KIND_FLOAT   = 3'd4;
    localparam logic [2:0] KIND_DOUBLE  = 3'd5;

    localparam int NUM_SPEC = 8;
    localparam int NUM_BAD  = 6;

    typedef struct packed {
        logic       valid;
        logic [2:0] kind;
    } t_res;

    localparam logic [2:0] SPEC_LEN [0:NUM_SPEC-1] = '{
        3'd3, 3'd4, 3'd4, 3'd5, 3'd4, 3'd5, 3'd3, 3'd4
    };

    localparam logic [7:0] SPEC_TXT [0:NUM_SPEC-1][0:4] = '{
        '{"i", "n", "f", 8'h00, 8'h00},
        '{"i", "n", "f", "f", 8'h00},
        '{"+", "i", "n", "f", 8'h00},
        '{"+", "i", "n", "f", "f"},
        '{"-", "i", "n", "f", 8'h00},
        '{"-", "i", "n", "f", "f"},
        '{"n", "a", "n", 8'h00, 8'h00},
        '{"n", "a", "n", "f", 8'h00}
    };

    localparam logic [2:0] BAD_LEN [0:NUM_BAD-1] = '{
        3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd3
    };

    localparam logic [7:0] BAD_TXT [0:NUM_BAD-1][0:2] = '{
        '{"-", ".", 8'h00},
        '{"+", ".", 8'h00},
        '{"+", ".", "f"},
        '{"+", ".", "F"},
        '{"-", ".", "f"},
        '{"-", ".", "F"}
    };

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_sign(input logic [7:0] c);
        return c inside {8'h2b, 8'h2d};
    endfunction

    function automatic logic spec_hit(input logic [2:0] k, input logic [2:0] p,
                                      input logic [7:0] c);
        logic hit;
        hit = 1'b0;
        if (p < SPEC_LEN[k]) begin
            hit = (SPEC_TXT[k][p] == c);
        end
        return hit;
    endfunction

    function automatic logic bad_hit(input logic [2:0] k, input logic [2:0] p,
                                     input logic [7:0] c);
        logic hit;
        hit = 1'b0;
        if (p < BAD_LEN[k]) begin
            hit = (BAD_TXT[k][p[1:0]] == c);
        end
        return hit;
    endfunction

endpackage

### rtl/core/slc_core.sv
module slc_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_take,
    input  logic [7:0]         i_ch,
    input  logic               i_last,
    output slc_pkg::t_res      o_res
);

    logic [2:0]                   r_count, n_count;
    logic [7:0]                   r_first, n_first;
    logic                         r_tail, n_tail;
    logic                         r_numok, n_numok;
    logic                         r_suffix, n_suffix;
    logic [1:0]                   r_dots, n_dots;
    logic [slc_pkg::NUM_SPEC-1:0] r_spec, n_spec;
    logic [slc_pkg::NUM_BAD-1:0]  r_bad, n_bad;

    logic       dig, dot, suf, body;
    logic       spec, bad;
    logic [2:0] kind;

    always_comb begin
        dig  = slc_pkg::is_digit(i_ch);
        dot  = (i_ch == 8'h2e);
        suf  = (i_ch == 8'h66) || (i_ch == 8'h46);
        body = dig || dot || ((r_count == 3'd0) && slc_pkg::is_sign(i_ch));

        for (int k = 0; k < slc_pkg::NUM_SPEC; k++) begin
            n_spec[k] = r_spec[k] && slc_pkg::spec_hit(3'(k), r_count, i_ch);
        end
        for (int k = 0; k < slc_pkg::NUM_BAD; k++) begin
            n_bad[k] = r_bad[k] && slc_pkg::bad_hit(3'(k), r_count, i_ch);
        end

        n_suffix = r_numok && suf;
        n_numok  = r_numok && body;
        n_first  = (r_count == 3'd0) ? i_ch : r_first;
        n_tail   = (r_count == 3'd0) ? r_tail : (r_tail && dig);
        n_dots   = (dot && (r_dots != 2'd2)) ? r_dots + 2'd1 : r_dots;
        n_count  = (r_count != 3'd7) ? r_count + 3'd1 : r_count;

        spec = 1'b0;
        for (int k = 0; k < slc_pkg::NUM_SPEC; k++) begin
            spec = spec || (n_spec[k] && (slc_pkg::SPEC_LEN[k] == n_count));
        end
        bad = 1'b0;
        for (int k = 0; k < slc_pkg::NUM_BAD; k++) begin
            bad = bad || (n_bad[k] && (slc_pkg::BAD_LEN[k] == n_count));
        end

        if (spec) begin
            kind = slc_pkg::KIND_SPECIAL;
        end else if ((n_count == 3'd1) && !slc_pkg::is_digit(n_first)) begin
            kind = slc_pkg::KIND_CHAR;
        end else if ((slc_pkg::is_digit(n_first) || slc_pkg::is_sign(n_first)) &&
                     ((n_count == 3'd1) || n_tail)) begin
            kind = slc_pkg::KIND_INT;
        end else if (bad) begin
            kind = slc_pkg::KIND_INVALID;
        end else if ((n_count >= 3'd3) && n_suffix && (n_dots == 2'd1)) begin
            kind = slc_pkg::KIND_FLOAT;
        end else if ((n_count >= 3'd2) && n_numok && (n_dots == 2'd1)) begin
            kind = slc_pkg::KIND_DOUBLE;
        end else begin
            kind = slc_pkg::KIND_INVALID;
        end

        o_res.valid = i_take && i_last;
        o_res.kind  = kind;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_last)) begin
            r_count  <= '0;
            r_first  <= '0;
            r_tail   <= 1'b1;
            r_numok  <= 1'b1;
            r_suffix <= 1'b0;
            r_dots   <= '0;
            r_spec   <= '1;
            r_bad    <= '1;
        end else if (i_take) begin
            r_count  <= n_count;
            r_first  <= n_first;
            r_tail   <= n_tail;
            r_numok  <= n_numok;
            r_suffix <= n_suffix;
            r_dots   <= n_dots;
            r_spec   <= n_spec;
            r_bad    <= n_bad;
        end
    end

endmodule

### rtl/core/scalar_literal_classifier_top.sv
// scalar literal classifier
// input channel: i_valid, i_ch, i_last, with o_stall back to the sender.
// one byte of the literal per beat, first byte first; i_last marks the
// final byte. a beat is taken on a clock edge with i_valid high and
// o_stall low.
// output channel: o_valid, o_kind, with i_stall from the receiver. one
// result beat per literal, given for its final byte only.
// throughput: one byte per cycle while o_stall is low, set by the single state update between
// the running state registers and the result register.
// the result of the final byte is registered in the output register, which drives o_valid.
// a stalled result holds in the output register; a second result parks
// in a one-entry skid register, and o_stall is high only while that
// skid register is full.
// reset (i_rst_n low, synchronous) empties both result registers and
// returns the running state to the start of a new literal.
module scalar_literal_classifier_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_ch,
    input  logic       i_last,
    output logic       o_stall,
    output logic       o_valid,
    output logic [2:0] o_kind,
    input  logic       i_stall
);

    slc_pkg::t_res res;
    slc_pkg::t_res r_out;
    slc_pkg::t_res r_skid;
    logic          take;
    logic          out_free;

    assign o_stall  = r_skid.valid;
    assign take     = i_valid && !r_skid.valid;
    assign out_free = !r_out.valid || !i_stall;
    assign o_valid  = r_out.valid;
    assign o_kind   = r_out.kind;

    slc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_ch    (i_ch),
        .i_last  (i_last),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid  <= 1'b0;
            r_skid.valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid.valid) begin
                r_out        <= r_skid;
                r_skid.valid <= 1'b0;
            end else begin
                r_out <= res;
            end
        end else if (res.valid) begin
            r_skid <= res;
        end
    end

endmodule

### tb/tb_scalar_literal_classifier_top.sv
`timescale 1ns / 100ps

module tb_scalar_literal_classifier_top;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int BEATS_PER_PHASE = 430;
    localparam int HOLDOFF_LEN     = 64;

    typedef enum logic [1:0] {
        IDLE_RX_HEAVY,
        IDLE_TX_HEAVY,
        IDLE_OFF
    } t_idle_mode;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_literal_beat;

    logic       i_clk   = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic [7:0] i_ch    = 8'h00;
    logic       i_last  = 1'b0;
    logic       i_stall = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [2:0] o_kind;

    t_idle_mode    idle_mode = IDLE_RX_HEAVY;
    t_literal_beat pending_beats [$];
    t_literal_beat next_beat;
    logic [7:0]    build_q [$];
    logic [7:0]    lit_bytes [$];
    logic [2:0]    kind_expected [$];
    logic [2:0]    kind_head;
    int            mismatch_count = 0;
    int            cycle_count    = 0;
    int            hold_cycles    = 0;
    bit            holdoff_req    = 1'b0;
    bit            holdoff_taken  = 1'b0;

    scalar_literal_classifier_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_ch    (i_ch),
        .i_last  (i_last),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_kind  (o_kind),
        .i_stall (i_stall)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic string special_word(input int idx);
        case (idx)
            0: return "inf";
            1: return "inff";
            2: return "+inf";
            3: return "+inff";
            4: return "-inf";
            5: return "-inff";
            6: return "nan";
            default: return "nanf";
        endcase
    endfunction

    function automatic string bad_pattern(input int idx);
        case (idx)
            0: return "-.";
            1: return "+.";
            2: return "+.f";
            3: return "+.F";
            4: return "-.f";
            default: return "-.F";
        endcase
    endfunction

    function automatic logic is_dec(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_pm(input logic [7:0] c);
        return c == "+" || c == "-";
    endfunction

    function automatic logic lit_equals(input string w);
        if (lit_bytes.size() != w.len()) begin
            return 1'b0;
        end
        for (int i = 0; i < w.len(); i++) begin
            if (lit_bytes[i] != w[i]) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // class of the literal held in lit_bytes, first matching rule wins
    function automatic logic [2:0] classify_literal();
        int         n;
        int         dots;
        logic       body_head;
        logic       body_all;
        logic       tail_digits;
        logic       is_special;
        logic       is_bad;
        logic [7:0] c;
        logic [7:0] first;
        logic [7:0] final_ch;
        n = lit_bytes.size();
        dots = 0;
        body_head = 1'b1;
        body_all = 1'b1;
        tail_digits = 1'b1;
        is_special = 1'b0;
        is_bad = 1'b0;
        first = lit_bytes[0];
        final_ch = lit_bytes[n-1];
        for (int i = 0; i < n; i++) begin
            c = lit_bytes[i];
            if (c == ".") begin
                dots++;
            end
            if (!(is_dec(c) || c == "." || (i == 0 && is_pm(c)))) begin
                body_all = 1'b0;
                if (i < n - 1) begin
                    body_head = 1'b0;
                end
            end
            if (i > 0 && !is_dec(c)) begin
                tail_digits = 1'b0;
            end
        end
        for (int k = 0; k < 8; k++) begin
            if (lit_equals(special_word(k))) begin
                is_special = 1'b1;
            end
        end
        for (int k = 0; k < 6; k++) begin
            if (lit_equals(bad_pattern(k))) begin
                is_bad = 1'b1;
            end
        end
        if (is_special) begin
            return slc_pkg::KIND_SPECIAL;
        end else if (n == 1 && !is_dec(first)) begin
            return slc_pkg::KIND_CHAR;
        end else if ((is_dec(first) || is_pm(first)) && tail_digits) begin
            return slc_pkg::KIND_INT;
        end else if (is_bad) begin
            return slc_pkg::KIND_INVALID;
        end else if (n >= 3 && body_head && (final_ch == "f" || final_ch == "F") &&
                     dots == 1) begin
            return slc_pkg::KIND_FLOAT;
        end else if (n >= 2 && body_all && dots == 1) begin
            return slc_pkg::KIND_DOUBLE;
        end
        return slc_pkg::KIND_INVALID;
    endfunction

    task automatic note_mismatch(input logic [2:0] want, input logic [2:0] got, input bit orphan);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            if (orphan) begin
                $display("mismatch: kind %0d arrived with nothing expected", got);
            end else begin
                $display("mismatch: kind expected %0d, actual %0d", want, got);
            end
        end
    endtask

    function automatic logic [7:0] pick_byte();
        string alpha = "0123456789.+-fFinaINx ";
        if ($urandom_range(0, 3) == 0) begin
            return 8'($urandom_range(0, 255));
        end
        return alpha[$urandom_range(0, alpha.len() - 1)];
    endfunction

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            build_q.push_back(s[i]);
        end
    endtask

    // optional sign, then digits with the given number of dots spread in
    task automatic add_body(input int dots, input int max_digits);
        int slots;
        int left_dots;
        if ($urandom_range(0, 2) == 0) begin
            build_q.push_back($urandom_range(0, 1) ? "+" : "-");
        end
        left_dots = dots;
        slots = $urandom_range(0, max_digits) + dots;
        for (int i = slots; i > 0; i--) begin
            if (left_dots > 0 && $urandom_range(0, i - 1) < left_dots) begin
                build_q.push_back(".");
                left_dots--;
            end else begin
                build_q.push_back(8'("0" + $urandom_range(0, 9)));
            end
        end
    endtask

    task automatic finish_literal();
        for (int i = 0; i < build_q.size(); i++) begin
            pending_beats.push_back({build_q[i], i == build_q.size() - 1});
        end
        build_q.delete();
    endtask

    task automatic gen_literal();
        int dots;
        int len;
        dots = $urandom_range(0, 9);
        dots = (dots == 0) ? 0 : (dots == 1) ? 2 : 1;
        case ($urandom_range(0, 11))
            0, 1: begin
                add_text(special_word($urandom_range(0, 7)));
            end
            2: begin
                add_text(bad_pattern($urandom_range(0, 5)));
            end
            3: begin
                add_text($urandom_range(0, 1) ? special_word($urandom_range(0, 7))
                                              : bad_pattern($urandom_range(0, 5)));
                case ($urandom_range(0, 2))
                    0: build_q[$urandom_range(0, build_q.size() - 1)] = pick_byte();
                    1: void'(build_q.pop_back());
                    default: build_q.push_back(pick_byte());
                endcase
            end
            4: begin
                add_body(0, 6);
            end
            5, 6: begin
                add_body(dots, 4);
                build_q.push_back($urandom_range(0, 1) ? "f" : "F");
            end
            7, 8: begin
                add_body(dots, 4);
            end
            9: begin
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++) begin
                    build_q.push_back(pick_byte());
                end
            end
            10: begin
                build_q.push_back(8'($urandom_range(0, 255)));
            end
            default: begin
                add_body(dots, 12);
                if ($urandom_range(0, 1)) begin
                    build_q.push_back($urandom_range(0, 1) ? "f" : "F");
                end
            end
        endcase
        if (build_q.size() == 0) begin
            build_q.push_back(pick_byte());
        end
        finish_literal();
    endtask

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                lit_bytes.push_back(i_ch);
                if (i_last) begin
                    kind_expected.push_back(classify_literal());
                    lit_bytes.delete();
                end
            end
            if (!i_valid || !o_stall) begin
                if (pending_beats.size() != 0 &&
                    $urandom_range(0, 99) >= (idle_mode == IDLE_RX_HEAVY ? 19 :
                                              idle_mode == IDLE_TX_HEAVY ? 75 : 0)) begin
                    next_beat = pending_beats.pop_front();
                    i_valid <= 1'b1;
                    i_ch <= next_beat.ch;
                    i_last <= next_beat.last;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall, with one long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            hold_cycles <= 0;
        end else if (holdoff_req && !holdoff_taken) begin
            holdoff_taken <= 1'b1;
            hold_cycles <= HOLDOFF_LEN - 1;
            i_stall <= 1'b1;
        end else if (hold_cycles != 0) begin
            hold_cycles <= hold_cycles - 1;
            i_stall <= 1'b1;
        end else begin
            case (idle_mode)
                IDLE_RX_HEAVY: i_stall <= $urandom_range(0, 99) < 75;
                IDLE_TX_HEAVY: i_stall <= $urandom_range(0, 99) < 19;
                default: i_stall <= 1'b0;
            endcase
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (kind_expected.size() == 0) begin
                note_mismatch(slc_pkg::KIND_INVALID, o_kind, 1'b1);
            end else begin
                kind_head = kind_expected.pop_front();
                if (o_kind !== kind_head) begin
                    note_mismatch(kind_head, o_kind, 1'b0);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        add_text("+inff");
        finish_literal();
        add_text("nan");
        finish_literal();
        add_text("-.F");
        finish_literal();
        add_text("+.");
        finish_literal();
        add_text("7");
        finish_literal();
        add_text(".5f");
        finish_literal();
        add_text("-12345678");
        finish_literal();
        add_text("3.1");
        finish_literal();
        build_q.push_back(8'h00);
        finish_literal();
        build_q.push_back(8'hff);
        finish_literal();
        for (int phase = 0; phase < 3; phase++) begin
            idle_mode <= (phase == 0) ? IDLE_RX_HEAVY :
                         (phase == 1) ? IDLE_TX_HEAVY : IDLE_OFF;
            while (pending_beats.size() < BEATS_PER_PHASE) begin
                gen_literal();
            end
            if (phase == 2) begin
                holdoff_req = 1'b1;
            end
            // sender pauses until every result is back
            while (pending_beats.size() != 0 || i_valid || kind_expected.size() != 0) begin
                @(negedge i_clk);
            end
        end
        repeat (8) @(negedge i_clk);
        if (mismatch_count == 0 && kind_expected.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
